@@ rtl/core/rrts_pkg.sv @@
`default_nettype none
package rrts_pkg;

	localparam int unsigned ID_W   = 8;
	localparam int unsigned ARR_W  = 12;
	localparam int unsigned BUR_W  = 12;
	localparam int unsigned TQ_W   = 12;
	localparam int unsigned OUT_TW = 17;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_DISP  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_ZERO    = 2'd2;
	localparam logic [1:0] ST_NOTHING = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LD_SRD,
		S_LD_SCHK,
		S_LD_MRD,
		S_LD_MWR,
		S_LD_WNEW,
		S_LD_FRD,
		S_LD_FWR,
		S_AD_RD,
		S_AD_CHK,
		S_DS_EMPTY,
		S_DS_FIND,
		S_DS_NEXT,
		S_DS_POP,
		S_DS_JRD,
		S_DS_RUN,
		S_DS_REQ,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

@@ rtl/core/rrts_ram.sv @@
`default_nettype none
module rrts_ram import rrts_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/round_robin_time_slice_scheduler.sv @@
// clear, unused mode and rejected load go straight to done; a load finds its slot by arrival,
// shifts later entries up and renumbers the queue; a dispatch admits arrivals to an empty queue,
// then runs the head or an idle gap (admission scans read the job table one entry at a time)
// one transaction at a time: s_tready is high only while the sequencer is idle
// reset: counters, flags, time and quantum (4) clear at once; table and queue memories
// hold no reset value and are only read where written
`default_nettype none
module round_robin_time_slice_scheduler import rrts_pkg::*; #(
	parameter int unsigned MAX_JOBS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire [11:0]  cfg_wr_data,  // time_quantum
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [31:0]  s_tdata,      // job_id[7:0], arrival[19:8], burst[31:20]
	input  wire [1:0]   s_tuser,      // mode
	output logic        m_tvalid,
	input  wire         m_tready,
	// slice_job[7:0], idle_slice[8], slice_start[25:9], slice_end[42:26],
	// job_finished[43], turnaround[60:44], waiting[77:61], response[94:78], all_done[95]
	output logic [95:0] m_tdata,
	output logic [1:0]  m_tuser       // status
);

	localparam int unsigned IW = $clog2(MAX_JOBS);
	localparam int unsigned CW = $clog2(MAX_JOBS + 1);
	localparam int unsigned TW = ARR_W + $clog2(MAX_JOBS + 1);
	localparam int unsigned SW = IW + 2;
	// job record: first_start, remaining, burst, arrival, id from the lowest bit
	localparam int unsigned REM_LO = TW;
	localparam int unsigned BUR_LO = TW + BUR_W;
	localparam int unsigned ARR_LO = TW + 2 * BUR_W;
	localparam int unsigned ID_LO  = ARR_LO + ARR_W;
	localparam int unsigned RW     = ID_LO + ID_W;

	state_t state_q, state_d, ret_q;

	// control state
	logic [TQ_W-1:0]     tq_q;
	logic [TW-1:0]       now_q, t_q;
	logic [IW-1:0]       head_q, ptr_q, pos_q, j_q;
	logic [CW-1:0]       fcnt_q, jcnt_q, fin_q, idx_q;
	logic [MAX_JOBS-1:0] adm_q, st_q;
	logic                ovalid_q, fin_flag_q;

	// latched transaction
	logic [ID_W-1:0]  in_id_q;
	logic [ARR_W-1:0] in_arr_q;
	logic [BUR_W-1:0] in_bur_q;

	// pending result
	logic [1:0]        r_status_q;
	logic [ID_W-1:0]   r_job_q;
	logic              r_idle_q, r_fin_q;
	logic [OUT_TW-1:0] r_start_q, r_end_q, r_ta_q, r_wait_q, r_resp_q;

	// memory ports
	logic          tab_we, fq_we;
	logic [IW-1:0] tab_waddr, tab_raddr, fq_waddr, fq_raddr;
	logic [RW-1:0] tab_wdata, tab_rdata;
	logic [IW-1:0] fq_wdata, fq_rdata;

	rrts_ram #(.WIDTH(RW), .DEPTH(MAX_JOBS)) u_table (
		.clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.raddr(tab_raddr), .rdata(tab_rdata)
	);

	rrts_ram #(.WIDTH(IW), .DEPTH(MAX_JOBS)) u_queue (
		.clk(clk), .we(fq_we), .waddr(fq_waddr), .wdata(fq_wdata),
		.raddr(fq_raddr), .rdata(fq_rdata)
	);

	// modular add on queue positions, the sum stays below twice the depth
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s >= SW'(MAX_JOBS)) begin
			s = s - SW'(MAX_JOBS);
		end
		return s[IW-1:0];
	endfunction

	wire             accept  = s_tvalid && s_tready;
	wire             out_ok  = !ovalid_q || m_tready;
	wire [IW-1:0]    idx_i   = idx_q[IW-1:0];
	wire [IW-1:0]    tail    = wrap_add(head_q, fcnt_q);
	wire [ARR_W-1:0] rd_arr  = tab_rdata[ARR_LO +: ARR_W];
	wire [BUR_W-1:0] rd_bur  = tab_rdata[BUR_LO +: BUR_W];
	wire [BUR_W-1:0] rd_rem  = tab_rdata[REM_LO +: BUR_W];
	wire [TW-1:0]    rd_fs   = tab_rdata[TW-1:0];
	wire [ID_W-1:0]  rd_id   = tab_rdata[ID_LO +: ID_W];
	wire [1:0]       s_mode  = s_tuser;
	wire [BUR_W-1:0] s_bur   = s_tdata[31:20];

	// slice arithmetic
	wire [TQ_W-1:0]  q_eff   = (tq_q == '0) ? TQ_W'(1) : tq_q;
	wire [BUR_W-1:0] run     = (rd_rem < q_eff) ? rd_rem : q_eff;
	wire [BUR_W-1:0] new_rem = rd_rem - run;
	wire [TW-1:0]    fs_new  = st_q[j_q] ? rd_fs : now_q;
	wire [TW-1:0]    now_run = now_q + TW'(run);
	wire [TW-1:0]    ta      = now_run - TW'(rd_arr);
	wire [TW-1:0]    wt      = ta - TW'(rd_bur);
	wire [TW-1:0]    resp    = fs_new - TW'(rd_arr);
	wire [TW-1:0]    now_idl = (TW'(rd_arr) > now_q) ? TW'(rd_arr) : now_q;

	// load: entries at and above the slot move up by one
	wire [MAX_JOBS-1:0] low_mask = (MAX_JOBS'(1) << pos_q) - MAX_JOBS'(1);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (s_mode)
						MODE_LOAD: begin
							if (s_bur == '0 || jcnt_q >= CW'(MAX_JOBS)) state_d = S_DONE;
							else state_d = S_LD_SRD;
						end
						MODE_DISP: state_d = (fcnt_q == '0) ? S_AD_RD : S_DS_POP;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_LD_SRD:   state_d = (idx_q == jcnt_q) ? S_LD_MRD : S_LD_SCHK;
			S_LD_SCHK:  state_d = (rd_arr > in_arr_q) ? S_LD_MRD : S_LD_SRD;
			S_LD_MRD:   state_d = (idx_i == pos_q) ? S_LD_WNEW : S_LD_MWR;
			S_LD_MWR:   state_d = S_LD_MRD;
			S_LD_WNEW:  state_d = S_LD_FRD;
			S_LD_FRD:   state_d = (idx_q == fcnt_q) ? S_DONE : S_LD_FWR;
			S_LD_FWR:   state_d = S_LD_FRD;
			S_AD_RD: begin
				if (idx_q == jcnt_q) state_d = ret_q;
				else if (!adm_q[idx_i]) state_d = S_AD_CHK;
			end
			S_AD_CHK:   state_d = S_AD_RD;
			S_DS_EMPTY: state_d = (fcnt_q != '0) ? S_DS_POP : S_DS_FIND;
			S_DS_FIND: begin
				if (idx_q == jcnt_q) state_d = S_DONE;
				else if (!adm_q[idx_i]) state_d = S_DS_NEXT;
			end
			S_DS_NEXT:  state_d = S_AD_RD;
			S_DS_POP:   state_d = S_DS_JRD;
			S_DS_JRD:   state_d = S_DS_RUN;
			S_DS_RUN:   state_d = S_AD_RD;
			S_DS_REQ:   state_d = S_DONE;
			S_DONE:     if (out_ok) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory addressing and writes
	always_comb begin
		tab_we    = 1'b0;
		tab_waddr = idx_i;
		tab_wdata = tab_rdata;
		tab_raddr = idx_i;
		fq_we     = 1'b0;
		fq_waddr  = tail;
		fq_wdata  = idx_i;
		fq_raddr  = ptr_q;
		unique case (state_q)
			S_LD_MRD: tab_raddr = IW'(idx_q - CW'(1));
			S_LD_MWR: tab_we = 1'b1;
			S_LD_WNEW: begin
				tab_we    = 1'b1;
				tab_waddr = pos_q;
				tab_wdata = {in_id_q, in_arr_q, in_bur_q, in_bur_q, TW'(0)};
			end
			S_LD_FWR: begin
				fq_we    = (fq_rdata >= pos_q);
				fq_waddr = ptr_q;
				fq_wdata = fq_rdata + IW'(1);
			end
			S_AD_CHK: fq_we = (TW'(rd_arr) <= t_q) && (fcnt_q < CW'(MAX_JOBS));
			S_DS_POP: fq_raddr = head_q;
			S_DS_JRD: tab_raddr = fq_rdata;
			S_DS_RUN: begin
				tab_we    = 1'b1;
				tab_waddr = j_q;
				tab_wdata = {rd_id, rd_arr, rd_bur, new_rem, fs_new};
			end
			S_DS_REQ: begin
				fq_we    = !fin_flag_q && (fcnt_q < CW'(MAX_JOBS));
				fq_wdata = j_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_DONE;
			tq_q       <= TQ_W'(4);
			now_q      <= '0;
			t_q        <= '0;
			head_q     <= '0;
			ptr_q      <= '0;
			pos_q      <= '0;
			j_q        <= '0;
			fcnt_q     <= '0;
			jcnt_q     <= '0;
			fin_q      <= '0;
			idx_q      <= '0;
			adm_q      <= '0;
			st_q       <= '0;
			ovalid_q   <= 1'b0;
			fin_flag_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) tq_q <= cfg_wr_data;
			if (state_q == S_DONE && out_ok) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (s_mode == MODE_CLEAR) begin
							adm_q  <= '0;
							st_q   <= '0;
							head_q <= '0;
							fcnt_q <= '0;
							jcnt_q <= '0;
							fin_q  <= '0;
							now_q  <= '0;
						end
						if (s_mode == MODE_DISP) begin
							t_q   <= now_q;
							ret_q <= S_DS_EMPTY;
						end
					end
				end
				S_LD_SRD: if (idx_q == jcnt_q) pos_q <= idx_i;
				S_LD_SCHK: begin
					if (rd_arr > in_arr_q) begin
						pos_q <= idx_i;
						idx_q <= jcnt_q;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_LD_MWR: idx_q <= idx_q - CW'(1);
				S_LD_WNEW: begin
					adm_q  <= (adm_q & low_mask) | ((adm_q & ~low_mask) << 1);
					st_q   <= (st_q & low_mask) | ((st_q & ~low_mask) << 1);
					jcnt_q <= jcnt_q + CW'(1);
					idx_q  <= '0;
					ptr_q  <= head_q;
				end
				S_LD_FWR: begin
					idx_q <= idx_q + CW'(1);
					ptr_q <= wrap_add(ptr_q, CW'(1));
				end
				S_AD_RD: if (idx_q != jcnt_q && adm_q[idx_i]) idx_q <= idx_q + CW'(1);
				S_AD_CHK: begin
					if (TW'(rd_arr) <= t_q) begin
						adm_q[idx_i] <= 1'b1;
						if (fcnt_q < CW'(MAX_JOBS)) fcnt_q <= fcnt_q + CW'(1);
					end
					idx_q <= idx_q + CW'(1);
				end
				S_DS_EMPTY: idx_q <= '0;
				S_DS_FIND: if (idx_q != jcnt_q && adm_q[idx_i]) idx_q <= idx_q + CW'(1);
				S_DS_NEXT: begin
					now_q <= now_idl;
					t_q   <= now_idl;
					idx_q <= '0;
					ret_q <= S_DONE;
				end
				S_DS_POP: begin
					head_q <= wrap_add(head_q, CW'(1));
					fcnt_q <= fcnt_q - CW'(1);
				end
				S_DS_JRD: j_q <= fq_rdata;
				S_DS_RUN: begin
					st_q[j_q]  <= 1'b1;
					now_q      <= now_run;
					t_q        <= now_run;
					fin_flag_q <= (new_rem == '0);
					idx_q      <= '0;
					ret_q      <= S_DS_REQ;
				end
				S_DS_REQ: begin
					if (fin_flag_q) fin_q <= fin_q + CW'(1);
					else if (fcnt_q < CW'(MAX_JOBS)) fcnt_q <= fcnt_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// transaction fields and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					in_id_q    <= s_tdata[7:0];
					in_arr_q   <= s_tdata[19:8];
					in_bur_q   <= s_bur;
					r_job_q    <= '0;
					r_idle_q   <= 1'b0;
					r_fin_q    <= 1'b0;
					r_start_q  <= '0;
					r_end_q    <= '0;
					r_ta_q     <= '0;
					r_wait_q   <= '0;
					r_resp_q   <= '0;
					r_status_q <= ST_OK;
					if (s_mode == MODE_LOAD) begin
						if (s_bur == '0) r_status_q <= ST_ZERO;
						else if (jcnt_q >= CW'(MAX_JOBS)) r_status_q <= ST_FULL;
					end
				end
			end
			S_DS_FIND: if (idx_q == jcnt_q) r_status_q <= ST_NOTHING;
			S_DS_NEXT: begin
				r_idle_q  <= 1'b1;
				r_start_q <= OUT_TW'(now_q);
				r_end_q   <= OUT_TW'(now_idl);
			end
			S_DS_RUN: begin
				r_job_q   <= rd_id;
				r_start_q <= OUT_TW'(now_q);
				r_end_q   <= OUT_TW'(now_run);
				if (new_rem == '0) begin
					r_fin_q  <= 1'b1;
					r_ta_q   <= OUT_TW'(ta);
					r_wait_q <= OUT_TW'(wt);
					r_resp_q <= OUT_TW'(resp);
				end
			end
			S_DONE: begin
				if (out_ok) begin
					m_tuser <= r_status_q;
					m_tdata <= {(fin_q == jcnt_q), r_resp_q, r_wait_q, r_ta_q, r_fin_q,
					            r_end_q, r_start_q, r_idle_q, r_job_q};
				end
			end
			default: ;
		endcase
	end

	// the queue never holds more jobs than the table
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= jcnt_q) else $error("queue count above job count");

	a_fin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q <= jcnt_q) else $error("finished count above job count");

	// a result is only presented once the sequencer has returned through done
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_DONE) else $error("result without done");

	// the sequencer only leaves idle on an accepted transaction
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !s_tvalid) |=> state_q == S_IDLE) else $error("spurious start");

endmodule
`default_nettype wire
